// File: hdl/tvn_pkg.sv
package tvn_pkg;

  localparam int FRAC_BITS = 16;
  // Coordinate width: pixel times scale plus the largest seed and offset.
  localparam int CW = 33;
  // Wrap period width: the largest period is set by the speckle layer.
  localparam int PW = 14;
  // Register stages of the remainder unit in each octave.
  localparam int RSTG = 5;
  localparam int OCT_LAT = RSTG + 4;

  localparam int PATCH_OCTAVES = 4;
  localparam int SPECKLE_OCTAVES = 3;
  localparam logic [12:0] MAX_SIZE = 13'd4096;

  localparam logic [15:0] SC_PATCH = 16'd2949;
  localparam logic [15:0] SC_SPECK = 16'd39322;
  localparam logic [23:0] SEED_X = 24'd13847757;
  localparam logic [24:0] SEED_Y = 25'd22144614;
  localparam logic [22:0] OFF_SX = 23'd6009651;
  localparam logic [19:0] OFF_SY = 20'd865075;

  // Octave sums and reciprocals for the normalizing divide by 15 and by 7.
  localparam int PSW = 20;
  localparam int SSW = 19;
  localparam logic [20:0] RECIP_P = 21'd1118482;
  localparam int RSH_P = 24;
  localparam logic [19:0] RECIP_S = 20'd599187;
  localparam int RSH_S = 22;

  localparam logic [15:0] MIX_P = 16'd36045;
  localparam logic [15:0] MIX_S = 16'd29491;

  localparam logic CFG_TEXTURE_SIZE = 1'b0;
  localparam logic CFG_VARIANT = 1'b1;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] alpha_level;
  } out_item_t;

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] w);
    logic [32:0] acc;
    acc = 33'(a) * (33'h10000 - 33'(w)) + 33'(b) * 33'(w);
    return acc[31:16];
  endfunction

  function automatic logic [15:0] smooth_sq(input logic [15:0] t);
    logic [31:0] pr;
    pr = 32'(t) * 32'(t);
    return pr[31:16];
  endfunction

  function automatic logic [15:0] smooth_fin(input logic [15:0] t2, input logic [15:0] t);
    logic [33:0] pr;
    pr = 34'(t2) * (34'd196608 - 34'({t, 1'b0}));
    return pr[31:16];
  endfunction

  function automatic logic [31:0] hash_a(input logic [PW-1:0] xi, input logic [PW-1:0] yi);
    return 32'(xi) * 32'd374761393 + 32'(yi) * 32'd668265263;
  endfunction

  function automatic logic [31:0] hash_b(input logic [31:0] h);
    return (h ^ (h >> 13)) * 32'd1274126177;
  endfunction

  function automatic logic [15:0] hash_c(input logic [31:0] h);
    logic [31:0] g;
    g = h ^ (h >> 16);
    return g[23:8];
  endfunction

  function automatic logic [PW-1:0] period_of(input logic [12:0] size,
                                               input logic [15:0] scale, input int oct);
    logic [33:0] pr;
    logic [17:0] r;
    pr = (34'(size) * 34'(scale)) << oct;
    pr = pr + 34'd32768;
    r = pr[33:16];
    if (r == 18'd0) begin
      r = 18'd1;
    end
    return PW'(r);
  endfunction

  function automatic logic [15:0] pal(input logic par, input logic [1:0] stop,
                                      input logic [1:0] ch);
    logic [15:0] v;
    case ({par, stop, ch})
      5'b0_00_00: v = 16'd5243;
      5'b0_00_01: v = 16'd5243;
      5'b0_00_10: v = 16'd5898;
      5'b0_01_00: v = 16'd9830;
      5'b0_01_01: v = 16'd9830;
      5'b0_01_10: v = 16'd10486;
      5'b0_10_00: v = 16'd15729;
      5'b0_10_01: v = 16'd15073;
      5'b0_10_10: v = 16'd14418;
      5'b1_00_00: v = 16'd6554;
      5'b1_00_01: v = 16'd3932;
      5'b1_00_10: v = 16'd1966;
      5'b1_01_00: v = 16'd13107;
      5'b1_01_01: v = 16'd8520;
      5'b1_01_10: v = 16'd4588;
      5'b1_10_00: v = 16'd20972;
      5'b1_10_01: v = 16'd13763;
      5'b1_10_10: v = 16'd7209;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/tiling_value_noise_texel.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_data   (pixel_x, pixel_y)
// out      output     out_valid / out_stall out_data  (red, green, blue, alpha levels)
// cfg      input      cfg_we                cfg_index, cfg_data
//
// One item enters per clock while the output is not stalled; it passes 15 register stages
// on its way to the output, and the first one loads at the edge that takes the item:
// one coordinate stage, the nine-stage octave pipeline with its five-stage remainder unit,
// and five stages for the sums, the divide, the mix, the palette and the output.
// Synchronous active-low reset clears the valid bits and variant, and sets size to 256.
// A stalled output freezes the whole pipeline; in_stall follows from it directly.
module tiling_value_noise_texel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tvn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tvn_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data
);
  import tvn_pkg::*;

  localparam int NST = 1 + OCT_LAT + 5;

  logic [12:0]    size_r, size_sat;
  logic [7:0]     var_r;
  logic [NST-1:0] vld_r;
  logic           en;

  logic [CW-1:0]  cxp_r, cyp_r, cxs_r, cys_r;
  logic [PW-1:0]  perp_r [PATCH_OCTAVES];
  logic [PW-1:0]  pers_r [SPECKLE_OCTAVES];
  logic [15:0]    npat [PATCH_OCTAVES];
  logic [15:0]    nspk [SPECKLE_OCTAVES];

  logic [PSW-1:0] psum, psum_r;
  logic [SSW-1:0] ssum, ssum_r;
  logic [40:0]    pprod;
  logic [38:0]    sprod;
  logic [15:0]    patch_r, speck_r;
  logic [32:0]    mix;
  logic [15:0]    t_r, w;
  logic [14:0]    col_r [3];
  logic [15:0]    bl [3];
  logic [23:0]    lv [3];
  out_item_t      out_r;

  assign en       = !vld_r[NST-1] || !out_stall;
  assign in_stall = !en;
  assign size_sat = (size_r > MAX_SIZE) ? MAX_SIZE : size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 13'd256;
      var_r  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXTURE_SIZE: size_r <= cfg_data;
        CFG_VARIANT:      var_r  <= cfg_data[7:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // Wrap periods depend on configuration only and are refreshed every cycle.
  always_ff @(posedge clk) begin
    for (int i = 0; i < PATCH_OCTAVES; i++) begin
      perp_r[i] <= period_of(size_sat, SC_PATCH, i);
    end
    for (int i = 0; i < SPECKLE_OCTAVES; i++) begin
      pers_r[i] <= period_of(size_sat, SC_SPECK, i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cxp_r <= CW'(in_data.pixel_x) * CW'(SC_PATCH) + CW'(var_r) * CW'(SEED_X);
      cyp_r <= CW'(in_data.pixel_y) * CW'(SC_PATCH) + CW'(var_r) * CW'(SEED_Y);
      cxs_r <= CW'(in_data.pixel_x) * CW'(SC_SPECK) + CW'(OFF_SX)
               + CW'(var_r) * CW'(SEED_X);
      cys_r <= CW'(in_data.pixel_y) * CW'(SC_SPECK) + CW'(OFF_SY)
               + CW'(var_r) * CW'(SEED_Y);
    end
  end

  for (genvar i = 0; i < PATCH_OCTAVES; i++) begin : g_patch
    tvn_octave #(.SHIFT(i)) u_oct (
      .clk    (clk),
      .en     (en),
      .cx     (cxp_r),
      .cy     (cyp_r),
      .period (perp_r[i]),
      .noise  (npat[i])
    );
  end

  for (genvar i = 0; i < SPECKLE_OCTAVES; i++) begin : g_speck
    tvn_octave #(.SHIFT(i)) u_oct (
      .clk    (clk),
      .en     (en),
      .cx     (cxs_r),
      .cy     (cys_r),
      .period (pers_r[i]),
      .noise  (nspk[i])
    );
  end

  // Coarser octaves weigh more; the rounding half of the total is added here.
  always_comb begin
    psum = PSW'(((1 << PATCH_OCTAVES) - 1) / 2);
    for (int i = 0; i < PATCH_OCTAVES; i++) begin
      psum = psum + (PSW'(npat[i]) << (PATCH_OCTAVES - 1 - i));
    end
    ssum = SSW'(((1 << SPECKLE_OCTAVES) - 1) / 2);
    for (int i = 0; i < SPECKLE_OCTAVES; i++) begin
      ssum = ssum + (SSW'(nspk[i]) << (SPECKLE_OCTAVES - 1 - i));
    end
  end

  assign pprod = 41'(psum_r) * 41'(RECIP_P);
  assign sprod = 39'(ssum_r) * 39'(RECIP_S);
  assign mix   = 33'(patch_r) * 33'(MIX_P) + 33'(speck_r) * 33'(MIX_S) + 33'd32768;
  assign w     = {t_r[14:0], 1'b0};

  for (genvar c = 0; c < 3; c++) begin : g_ch
    assign bl[c] = blend(pal(var_r[0], {1'b0, t_r[15]}, 2'(c)),
                         pal(var_r[0], {t_r[15], !t_r[15]}, 2'(c)), w);
    assign lv[c] = 24'(col_r[c]) * 24'd255;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      psum_r  <= psum;
      ssum_r  <= ssum;
      patch_r <= pprod[RSH_P+15:RSH_P];
      speck_r <= sprod[RSH_S+15:RSH_S];
      t_r     <= mix[31:16];
      for (int c = 0; c < 3; c++) begin
        col_r[c] <= bl[c][15:1];
      end
      out_r.red_level   <= lv[0][23:16];
      out_r.green_level <= lv[1][23:16];
      out_r.blue_level  <= lv[2][23:16];
      out_r.alpha_level <= 8'd255;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

endmodule

// File: hdl/tvn_octave.sv
module tvn_octave #(
  parameter int SHIFT = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [tvn_pkg::CW-1:0] cx,
  input  logic [tvn_pkg::CW-1:0] cy,
  input  logic [tvn_pkg::PW-1:0] period,
  output logic [15:0]            noise
);
  import tvn_pkg::*;

  localparam int XW = CW + SHIFT - FRAC_BITS;
  localparam int RSTEP = (XW + RSTG - 1) / RSTG;
  localparam int PADW = RSTEP * RSTG;

  function automatic logic [PW-1:0] mod_chunk(input logic [PW-1:0] rem,
                                              input logic [RSTEP-1:0] bits,
                                              input logic [PW-1:0] p);
    logic [PW:0] r;
    r = {1'b0, rem};
    for (int j = RSTEP - 1; j >= 0; j--) begin
      r = {r[PW-1:0], bits[j]};
      if (r >= {1'b0, p}) begin
        r = r - {1'b0, p};
      end
    end
    return r[PW-1:0];
  endfunction

  logic [CW+SHIFT-1:0] cxs, cys;
  logic [PADW-1:0]     xpad, ypad;
  logic [15:0]         tx, ty;
  logic [PADW-1:0]     xpad_r [RSTG-1];
  logic [PADW-1:0]     ypad_r [RSTG-1];
  logic [PW-1:0]       remx_r [RSTG];
  logic [PW-1:0]       remy_r [RSTG];
  logic [15:0]         tx_r, ty_r, t2x_r, t2y_r;
  logic [15:0]         sx_r [RSTG+1];
  logic [15:0]         sy_r [RSTG+2];
  logic [PW-1:0]       wx0, wy0, wx1, wy1, wxi, wyi;
  logic [31:0]         h1_r [4];
  logic [31:0]         h2_r [4];
  logic [15:0]         hv [4];
  logic [15:0]         r0_r, r1_r, noise_r;

  assign cxs  = (CW + SHIFT)'(cx) << SHIFT;
  assign cys  = (CW + SHIFT)'(cy) << SHIFT;
  assign xpad = PADW'(cxs[CW+SHIFT-1:FRAC_BITS]);
  assign ypad = PADW'(cys[CW+SHIFT-1:FRAC_BITS]);
  assign tx   = cxs[FRAC_BITS-1:0];
  assign ty   = cys[FRAC_BITS-1:0];

  // First remainder step, the square of the fractions, and the eased fractions from that square.
  always_ff @(posedge clk) begin
    if (en) begin
      remx_r[0] <= mod_chunk('0, xpad[PADW-1 -: RSTEP], period);
      remy_r[0] <= mod_chunk('0, ypad[PADW-1 -: RSTEP], period);
      xpad_r[0] <= xpad;
      ypad_r[0] <= ypad;
      tx_r      <= tx;
      ty_r      <= ty;
      t2x_r     <= smooth_sq(tx);
      t2y_r     <= smooth_sq(ty);
      sx_r[0]   <= smooth_fin(t2x_r, tx_r);
      sy_r[0]   <= smooth_fin(t2y_r, ty_r);
    end
  end

  for (genvar k = 1; k < RSTG; k++) begin : g_rem
    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[k] <= mod_chunk(remx_r[k-1], xpad_r[k-1][PADW-1-k*RSTEP -: RSTEP], period);
        remy_r[k] <= mod_chunk(remy_r[k-1], ypad_r[k-1][PADW-1-k*RSTEP -: RSTEP], period);
      end
    end
    if (k < RSTG - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          xpad_r[k] <= xpad_r[k-1];
          ypad_r[k] <= ypad_r[k-1];
        end
      end
    end
  end

  for (genvar j = 1; j < RSTG + 2; j++) begin : g_sdly
    always_ff @(posedge clk) begin
      if (en) begin
        sy_r[j] <= sy_r[j-1];
      end
    end
    if (j < RSTG + 1) begin : g_sx
      always_ff @(posedge clk) begin
        if (en) begin
          sx_r[j] <= sx_r[j-1];
        end
      end
    end
  end

  // The far corner wraps to zero when it reaches the period.
  assign wx0 = remx_r[RSTG-1];
  assign wy0 = remy_r[RSTG-1];
  assign wxi = wx0 + PW'(1);
  assign wyi = wy0 + PW'(1);
  assign wx1 = (wxi == period) ? '0 : wxi;
  assign wy1 = (wyi == period) ? '0 : wyi;

  for (genvar c = 0; c < 4; c++) begin : g_hv
    assign hv[c] = hash_c(h2_r[c]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r[0] <= hash_a(wx0, wy0);
      h1_r[1] <= hash_a(wx1, wy0);
      h1_r[2] <= hash_a(wx0, wy1);
      h1_r[3] <= hash_a(wx1, wy1);
      for (int c = 0; c < 4; c++) begin
        h2_r[c] <= hash_b(h1_r[c]);
      end
      r0_r    <= blend(hv[0], hv[1], sx_r[RSTG]);
      r1_r    <= blend(hv[2], hv[3], sx_r[RSTG]);
      noise_r <= blend(r0_r, r1_r, sy_r[RSTG+1]);
    end
  end

  assign noise = noise_r;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import tvn_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [12:0] cfg_data;

  tiling_value_noise_texel dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the two registers.
  logic [12:0] size_reg;
  logic [7:0] variant_reg;

  out_item_t texel_q[$];
  int n_taken;
  int n_texels;
  int n_errors;
  int n_cycles;
  int stall_mode;
  bit hold_req;

  // Fixed-point constants, rounded to 16 fraction bits.
  localparam longint unsigned Q_ONE = 64'd65536;
  localparam longint unsigned K_SEED_X = ((64'd2113 << 16) + 5) / 10;
  localparam longint unsigned K_SEED_Y = ((64'd3379 << 16) + 5) / 10;
  localparam longint unsigned K_SC_PATCH = ((64'd45 << 16) + 500) / 1000;
  localparam longint unsigned K_SC_SPECK = ((64'd6 << 16) + 5) / 10;
  localparam longint unsigned K_OFF_X = ((64'd917 << 16) + 5) / 10;
  localparam longint unsigned K_OFF_Y = ((64'd132 << 16) + 5) / 10;

  // Palette stops in hundredths: parity, stop, channel.
  int unsigned stop_pct[2][3][3] = '{
    '{'{8, 8, 9}, '{15, 15, 16}, '{24, 23, 22}},
    '{'{10, 6, 3}, '{20, 13, 7}, '{32, 21, 11}}
  };

  function automatic longint unsigned corner_value(longint unsigned xi, longint unsigned yi);
    logic [31:0] h;
    h = xi[31:0] * 32'd374761393 + yi[31:0] * 32'd668265263;
    h = (h ^ (h >> 13)) * 32'd1274126177;
    h = h ^ (h >> 16);
    return longint'(h[23:8]);
  endfunction

  function automatic longint unsigned lerp_q16(longint unsigned a, longint unsigned b,
                                              longint unsigned w);
    return (a * (Q_ONE - w) + b * w) >> 16;
  endfunction

  function automatic longint unsigned ease_q16(longint unsigned t);
    longint unsigned t2;
    t2 = (t * t) >> 16;
    return (t2 * (3 * Q_ONE - 2 * t)) >> 16;
  endfunction

  function automatic longint unsigned octave_value(longint unsigned cx, longint unsigned cy,
                                                  longint unsigned period);
    longint unsigned x0, y0, sx, sy, r0, r1;
    x0 = cx >> 16;
    y0 = cy >> 16;
    sx = ease_q16(cx & 64'hFFFF);
    sy = ease_q16(cy & 64'hFFFF);
    r0 = lerp_q16(corner_value(x0 % period, y0 % period),
                  corner_value((x0 + 1) % period, y0 % period), sx);
    r1 = lerp_q16(corner_value(x0 % period, (y0 + 1) % period),
                  corner_value((x0 + 1) % period, (y0 + 1) % period), sx);
    return lerp_q16(r0, r1, sy);
  endfunction

  function automatic longint unsigned fbm_value(longint unsigned cx, longint unsigned cy,
                                               int octaves, longint unsigned size,
                                               longint unsigned scale);
    longint unsigned acc, total, period;
    acc = 0;
    total = (64'd1 << octaves) - 1;
    for (int i = 0; i < octaves; i++) begin
      period = (((size * scale) << i) + 64'd32768) >> 16;
      if (period == 0) begin
        period = 1;
      end
      acc += octave_value(cx << i, cy << i, period) << (octaves - 1 - i);
    end
    return (acc + total / 2) / total;
  endfunction

  function automatic out_item_t predict_texel(in_item_t px);
    longint unsigned size, v, patch, speck, t, w, a, b, col;
    int lo;
    out_item_t r;
    size = (size_reg > 13'd4096) ? 64'd4096 : longint'(size_reg);
    v = longint'(variant_reg);
    patch = fbm_value(px.pixel_x * K_SC_PATCH + v * K_SEED_X,
                      px.pixel_y * K_SC_PATCH + v * K_SEED_Y,
                      PATCH_OCTAVES, size, K_SC_PATCH);
    speck = fbm_value(px.pixel_x * K_SC_SPECK + K_OFF_X + v * K_SEED_X,
                      px.pixel_y * K_SC_SPECK + K_OFF_Y + v * K_SEED_Y,
                      SPECKLE_OCTAVES, size, K_SC_SPECK);
    t = (patch * 36045 + speck * 29491 + 32768) >> 16;
    if (t > 65535) begin
      t = 65535;
    end
    if (t < 32768) begin
      lo = 0;
      w = t * 2;
    end else begin
      lo = 1;
      w = (t - 32768) * 2;
    end
    for (int c = 0; c < 3; c++) begin
      a = (longint'(stop_pct[v[0]][lo][c]) * Q_ONE + 50) / 100;
      b = (longint'(stop_pct[v[0]][lo + 1][c]) * Q_ONE + 50) / 100;
      col = lerp_q16(a, b, w) >> 1;
      col = (col * 255) >> 16;
      case (c)
        0: r.red_level = col[7:0];
        1: r.green_level = col[7:0];
        default: r.blue_level = col[7:0];
      endcase
    end
    r.alpha_level = 8'd255;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Acceptance on both channels, sampled at the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("status: fail");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      texel_q.push_back(predict_texel(in_data));
      n_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_texels++;
      if (texel_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected texel %h", $time, out_data);
      end else begin
        want = texel_q.pop_front();
        if (out_data.red_level !== want.red_level) begin
          n_errors++;
          $display("%0t: red exp %0d got %0d", $time, want.red_level, out_data.red_level);
        end
        if (out_data.green_level !== want.green_level) begin
          n_errors++;
          $display("%0t: green exp %0d got %0d", $time, want.green_level,
                   out_data.green_level);
        end
        if (out_data.blue_level !== want.blue_level) begin
          n_errors++;
          $display("%0t: blue exp %0d got %0d", $time, want.blue_level, out_data.blue_level);
        end
        if (out_data.alpha_level !== want.alpha_level) begin
          n_errors++;
          $display("%0t: alpha exp %0d got %0d", $time, want.alpha_level,
                   out_data.alpha_level);
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off on request.
  initial begin
    int hold_left;
    int phase_cnt;
    hold_left = 0;
    phase_cnt = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      phase_cnt++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= (phase_cnt % 7) < 3;
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic idx, logic [12:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TEXTURE_SIZE) begin
      size_reg = value;
    end else begin
      variant_reg = value[7:0];
    end
  endtask

  // Offer one item at the falling edge and hold it until it is taken.
  task automatic offer_pixel(logic [11:0] px, logic [11:0] py, int gap);
    int target;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{pixel_x: px, pixel_y: py};
    target = n_taken + 1;
    wait (n_taken == target);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (texel_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  // Random burst of pixels; mostly inside the texture, some anywhere.
  task automatic random_burst(int count);
    int burst;
    int gap;
    logic [11:0] lim;
    burst = 0;
    lim = (size_reg == 0) ? 12'd0 : (size_reg > 13'd4096) ? 12'd4095 : 12'(size_reg - 1);
    for (int k = 0; k < count; k++) begin
      gap = 0;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst--;
      if ($urandom_range(0, 4) == 0) begin
        offer_pixel(12'($urandom), 12'($urandom), gap);
      end else begin
        offer_pixel(12'($urandom_range(0, lim)), 12'($urandom_range(0, lim)), gap);
      end
    end
  endtask

  typedef struct {
    logic [11:0] px;
    logic [11:0] py;
  } pixel_row_t;

  pixel_row_t corner_rows[] = '{
    '{12'd0, 12'd0}, '{12'd4095, 12'd4095}, '{12'd4095, 12'd0}, '{12'd0, 12'd4095},
    '{12'd255, 12'd255}, '{12'd256, 12'd256}, '{12'd255, 12'd0}, '{12'd1, 12'd1},
    '{12'd128, 12'd77}, '{12'd2730, 12'd1365}, '{12'd1365, 12'd2730}, '{12'd22, 12'd23},
    '{12'd2048, 12'd2048}, '{12'd511, 12'd3}
  };

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TEXTURE_SIZE;
    cfg_data = '0;
    size_reg = 13'd256;
    variant_reg = 8'd0;
    n_taken = 0;
    n_texels = 0;
    n_errors = 0;
    n_cycles = 0;
    stall_mode = 0;
    hold_req = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: corners, outside-texture pixels, back-to-back items.
    foreach (corner_rows[i]) begin
      offer_pixel(corner_rows[i].px, corner_rows[i].py, (i % 4 == 3) ? 2 : 0);
    end
    drain();

    // Largest texture, largest variant, with a long receiver hold-off.
    write_reg(CFG_TEXTURE_SIZE, 13'd4096);
    write_reg(CFG_VARIANT, 13'd255);
    stall_mode = 1;
    hold_req = 1'b1;
    random_burst(110);
    drain();

    // Size zero collapses every lattice to one cell.
    write_reg(CFG_TEXTURE_SIZE, 13'd0);
    write_reg(CFG_VARIANT, 13'd1);
    stall_mode = 2;
    offer_pixel(12'd4095, 12'd4095, 0);
    random_burst(60);
    drain();

    // Smallest legal size and oversize that saturates.
    write_reg(CFG_TEXTURE_SIZE, 13'd1);
    write_reg(CFG_VARIANT, 13'd0);
    stall_mode = 3;
    random_burst(60);
    drain();
    write_reg(CFG_TEXTURE_SIZE, 13'd8191);
    write_reg(CFG_VARIANT, 13'd170);
    stall_mode = 0;
    random_burst(100);
    drain();

    // A few random settings.
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_TEXTURE_SIZE, 13'($urandom_range(1, 4096)));
      write_reg(CFG_VARIANT, 13'($urandom_range(0, 255)));
      stall_mode = $urandom_range(0, 3);
      random_burst(55);
      drain();
    end

    $display("covered %0d pixels, %0d texels, sizes 0/1/4096/oversize/random, variants 0..255",
             n_taken, n_texels);
    if (n_errors == 0 && texel_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d texels still expected", n_errors, texel_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/tvn_pkg.sv
hdl/tvn_octave.sv
hdl/tiling_value_noise_texel.sv
tb/tb.sv
